// File: hdl/qrrs_pkg.sv
`timescale 1ns / 1ps
package qrrs_pkg;

  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_WIDTH  = 48;

  // discriminant is exact: two products plus the factor four
  localparam int PROD_W = 2 * COEF_WIDTH;
  localparam int DISC_W = PROD_W + 2;
  localparam int ROOT_W = DISC_W / 2;
  // |-b +/- root| needs one bit more than the root
  localparam int MAG_W  = ROOT_W + 1;
  localparam int NUM_W  = MAG_W + FRAC_BITS;
  localparam int DIV_W  = COEF_WIDTH + 1;
  localparam int CMP_W  = (NUM_W > OUT_WIDTH) ? NUM_W : OUT_WIDTH;

  localparam logic [CMP_W-1:0] SAT_MAG = {{(CMP_W-1){1'b0}}, 1'b1} << (OUT_WIDTH - 1);
  localparam logic [CMP_W-1:0] POS_LIM = SAT_MAG - {{(CMP_W-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROOTS = 2'd1,
    ST_A_ZERO   = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef struct packed {
    status_t               status;
    logic                  a_neg;
    logic [COEF_WIDTH-1:0] a_mag;
    logic                  b_neg;
    logic [COEF_WIDTH-1:0] b_mag;
  } meta_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] root_plus;
    logic signed [OUT_WIDTH-1:0] root_minus;
    status_t                     status;
  } res_t;

endpackage

// File: hdl/qrrs_in_if.sv
`timescale 1ns / 1ps
interface qrrs_in_if;
  import qrrs_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

// File: hdl/qrrs_out_if.sv
`timescale 1ns / 1ps
interface qrrs_out_if;
  import qrrs_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] root_plus;
  logic signed [OUT_WIDTH-1:0] root_minus;
  logic [1:0]                  status;

  modport source (output valid, output root_plus, output root_minus, output status,
                  input ready);
  modport sink   (input valid, input root_plus, input root_minus, input status,
                  output ready);
endinterface

// File: hdl/qrrs_disc.sv
`timescale 1ns / 1ps
module qrrs_disc (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic [qrrs_pkg::COEF_WIDTH-1:0]    coef_a,
  input  logic [qrrs_pkg::COEF_WIDTH-1:0]    coef_b,
  input  logic [qrrs_pkg::COEF_WIDTH-1:0]    coef_c,
  output logic                               out_valid,
  output logic [qrrs_pkg::DISC_W-1:0]        out_disc,
  output qrrs_pkg::meta_t                    out_meta
);
  import qrrs_pkg::*;

  logic                  v1_r, v2_r, v3_r;
  meta_t                 m1_r, m2_r, m3_r;
  meta_t                 m1_nxt, m3_nxt;
  logic [COEF_WIDTH-1:0] c_mag1_r, c_mag1_nxt;
  logic                  c_neg1_r, c_neg1_nxt;
  logic [PROD_W-1:0]     bb2_r, ac2_r, bb2_nxt, ac2_nxt;
  logic                  same2_r;
  logic [DISC_W-1:0]     disc3_r, disc3_nxt;
  logic [DISC_W-1:0]     bb_x, ac4_x;

  always_comb begin
    m1_nxt.a_neg = coef_a[COEF_WIDTH-1];
    m1_nxt.a_mag = coef_a[COEF_WIDTH-1] ? -coef_a : coef_a;
    m1_nxt.b_neg = coef_b[COEF_WIDTH-1];
    m1_nxt.b_mag = coef_b[COEF_WIDTH-1] ? -coef_b : coef_b;
    m1_nxt.status = (coef_a == '0) ? ST_A_ZERO : ST_OK;
    c_neg1_nxt = coef_c[COEF_WIDTH-1];
    c_mag1_nxt = coef_c[COEF_WIDTH-1] ? -coef_c : coef_c;
  end

  always_comb begin
    bb2_nxt = PROD_W'(m1_r.b_mag) * PROD_W'(m1_r.b_mag);
    ac2_nxt = PROD_W'(m1_r.a_mag) * PROD_W'(c_mag1_r);
  end

  always_comb begin
    bb_x  = DISC_W'(bb2_r);
    ac4_x = {ac2_r, 2'b00};
    m3_nxt = m2_r;
    if (!same2_r) begin
      disc3_nxt = bb_x + ac4_x;
    end else begin
      disc3_nxt = bb_x - ac4_x;
      // flag negative discriminant unless a is already degenerate
      if (m2_r.status == ST_OK && bb_x < ac4_x) begin
        m3_nxt.status = ST_NO_ROOTS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r     <= m1_nxt;
      c_mag1_r <= c_mag1_nxt;
      c_neg1_r <= c_neg1_nxt;
      m2_r     <= m1_r;
      bb2_r    <= bb2_nxt;
      ac2_r    <= ac2_nxt;
      same2_r  <= (m1_r.a_neg == c_neg1_r);
      m3_r     <= m3_nxt;
      disc3_r  <= disc3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_disc  = disc3_r;
  assign out_meta  = m3_r;
endmodule

// File: hdl/qrrs_sqrt.sv
`timescale 1ns / 1ps
module qrrs_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [qrrs_pkg::DISC_W-1:0]   in_disc,
  input  qrrs_pkg::meta_t               in_meta,
  output logic                          out_valid,
  output logic [qrrs_pkg::ROOT_W-1:0]   out_root,
  output qrrs_pkg::meta_t               out_meta
);
  import qrrs_pkg::*;

  localparam int SRW = ROOT_W + 2;

  // one result bit per stage, restoring digit recurrence
  logic              v_r    [1:ROOT_W];
  meta_t             m_r    [1:ROOT_W];
  logic [DISC_W-1:0] x_r    [1:ROOT_W];
  logic [SRW-1:0]    rem_r  [1:ROOT_W];
  logic [ROOT_W-1:0] root_r [1:ROOT_W];

  logic              v_c    [0:ROOT_W-1];
  meta_t             m_c    [0:ROOT_W-1];
  logic [DISC_W-1:0] x_c    [0:ROOT_W-1];
  logic [SRW-1:0]    rem_c  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_c [0:ROOT_W-1];

  logic [DISC_W-1:0] x_nxt    [1:ROOT_W];
  logic [SRW-1:0]    rem_nxt  [1:ROOT_W];
  logic [ROOT_W-1:0] root_nxt [1:ROOT_W];

  logic [SRW-1:0]    rem_sh, trial;
  logic              ge;

  always_comb begin
    v_c[0]    = in_valid;
    m_c[0]    = in_meta;
    x_c[0]    = in_disc;
    rem_c[0]  = '0;
    root_c[0] = '0;
    for (int i = 1; i < ROOT_W; i++) begin
      v_c[i]    = v_r[i];
      m_c[i]    = m_r[i];
      x_c[i]    = x_r[i];
      rem_c[i]  = rem_r[i];
      root_c[i] = root_r[i];
    end
  end

  always_comb begin
    rem_sh = '0;
    trial  = '0;
    ge     = 1'b0;
    for (int i = 0; i < ROOT_W; i++) begin
      rem_sh = {rem_c[i][SRW-3:0], x_c[i][DISC_W-1 -: 2]};
      trial  = {root_c[i], 2'b01};
      ge     = (rem_sh >= trial);
      rem_nxt[i+1]  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt[i+1] = {root_c[i][ROOT_W-2:0], ge};
      x_nxt[i+1]    = x_c[i] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= ROOT_W; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      for (int i = 1; i <= ROOT_W; i++) v_r[i] <= v_c[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i <= ROOT_W; i++) begin
        m_r[i]    <= m_c[i-1];
        x_r[i]    <= x_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
      end
    end
  end

  assign out_valid = v_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_meta  = m_r[ROOT_W];
endmodule

// File: hdl/qrrs_div.sv
`timescale 1ns / 1ps
module qrrs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [qrrs_pkg::ROOT_W-1:0]   in_root,
  input  qrrs_pkg::meta_t               in_meta,
  output logic                          out_valid,
  output qrrs_pkg::res_t                out_res
);
  import qrrs_pkg::*;

  // lane 0 carries -b + root, lane 1 carries -b - root
  logic              v_r   [0:NUM_W];
  status_t           st_r  [0:NUM_W];
  logic [DIV_W-1:0]  d_r   [0:NUM_W];
  logic [NUM_W-1:0]  n_r   [0:1][0:NUM_W];
  logic              sg_r  [0:1][0:NUM_W];
  logic [DIV_W-1:0]  rem_r [0:1][1:NUM_W];

  logic [NUM_W-1:0]  n0_nxt   [0:1];
  logic              sg0_nxt  [0:1];
  logic [NUM_W-1:0]  n_nxt    [0:1][1:NUM_W];
  logic [DIV_W-1:0]  rem_nxt  [0:1][1:NUM_W];

  logic signed [MAG_W:0] nb_s, rt_s;
  logic signed [MAG_W:0] num_s [0:1];
  logic [MAG_W-1:0]      mag;
  logic [DIV_W-1:0]      rem_src;
  logic [DIV_W:0]        rsh, dd;
  logic                  ge;

  logic                   out_v_r;
  res_t                   res_r, res_nxt;
  logic [CMP_W-1:0]       qx;
  logic                   is_neg;
  logic                   sat [0:1];
  logic [OUT_WIDTH-1:0]   mval;
  logic [OUT_WIDTH-1:0]   val [0:1];

  // numerator stage: form -b +/- root, take magnitude, scale by the fraction
  always_comb begin
    nb_s = (MAG_W+1)'(in_meta.b_mag);
    if (!in_meta.b_neg) nb_s = -nb_s;
    rt_s = (MAG_W+1)'(in_root);
    num_s[0] = nb_s + rt_s;
    num_s[1] = nb_s - rt_s;
    mag = '0;
    for (int l = 0; l < 2; l++) begin
      mag = num_s[l][MAG_W] ? MAG_W'(-num_s[l]) : MAG_W'(num_s[l]);
      n0_nxt[l]  = NUM_W'(mag) << FRAC_BITS;
      sg0_nxt[l] = num_s[l][MAG_W] ^ in_meta.a_neg;
    end
  end

  // restoring division, one quotient bit per stage shifted into the low end
  always_comb begin
    rem_src = '0;
    rsh     = '0;
    dd      = '0;
    ge      = 1'b0;
    for (int k = 0; k < NUM_W; k++) begin
      for (int l = 0; l < 2; l++) begin
        rem_src = (k == 0) ? '0 : rem_r[l][k];
        rsh = {rem_src, n_r[l][k][NUM_W-1]};
        dd  = {1'b0, d_r[k]};
        ge  = (rsh >= dd);
        rem_nxt[l][k+1] = ge ? DIV_W'(rsh - dd) : rsh[DIV_W-1:0];
        n_nxt[l][k+1]   = {n_r[l][k][NUM_W-2:0], ge};
      end
    end
  end

  always_comb begin
    qx     = '0;
    is_neg = 1'b0;
    mval   = '0;
    for (int l = 0; l < 2; l++) begin
      qx     = CMP_W'(n_r[l][NUM_W]);
      is_neg = sg_r[l][NUM_W] && (qx != '0);
      if (is_neg) begin
        sat[l] = (qx > SAT_MAG);
        mval   = sat[l] ? SAT_MAG[OUT_WIDTH-1:0] : qx[OUT_WIDTH-1:0];
        val[l] = -mval;
      end else begin
        sat[l] = (qx > POS_LIM);
        mval   = sat[l] ? POS_LIM[OUT_WIDTH-1:0] : qx[OUT_WIDTH-1:0];
        val[l] = mval;
      end
    end
    if (st_r[NUM_W] != ST_OK) begin
      res_nxt.root_plus  = '0;
      res_nxt.root_minus = '0;
      res_nxt.status     = st_r[NUM_W];
    end else begin
      res_nxt.root_plus  = val[0];
      res_nxt.root_minus = val[1];
      res_nxt.status     = (sat[0] || sat[1]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NUM_W; k++) v_r[k] <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= NUM_W; k++) v_r[k] <= v_r[k-1];
      out_v_r <= v_r[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= in_meta.status;
      d_r[0]  <= {in_meta.a_mag, 1'b0};
      for (int l = 0; l < 2; l++) begin
        n_r[l][0]  <= n0_nxt[l];
        sg_r[l][0] <= sg0_nxt[l];
      end
      for (int k = 1; k <= NUM_W; k++) begin
        st_r[k] <= st_r[k-1];
        d_r[k]  <= d_r[k-1];
        for (int l = 0; l < 2; l++) begin
          n_r[l][k]   <= n_nxt[l][k];
          rem_r[l][k] <= rem_nxt[l][k];
          sg_r[l][k]  <= sg_r[l][k-1];
        end
      end
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = res_r;
endmodule

// File: hdl/quadratic_real_root_solver_top.sv
`timescale 1ns / 1ps
// Stages from input transaction to result valid: 3 discriminant, 33 square-root,
//   1 numerator, 50 divide and 1 saturation stages.
// Throughput: one transaction per cycle; every stage holds while the output
//   register is full and not taken.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
module quadratic_real_root_solver_top (
  input  logic        clk,
  input  logic        rst_n,
  qrrs_in_if.sink     in_ch,
  qrrs_out_if.source  out_ch
);
  import qrrs_pkg::*;

  logic              adv;
  logic              d_valid, s_valid, o_valid;
  logic [DISC_W-1:0] d_disc;
  meta_t             d_meta, s_meta;
  logic [ROOT_W-1:0] s_root;
  res_t              o_res;

  // advance the whole pipeline unless the result waits
  assign adv         = !o_valid || out_ch.ready;
  assign in_ch.ready = adv;

  qrrs_disc u_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .coef_a    (in_ch.coef_a),
    .coef_b    (in_ch.coef_b),
    .coef_c    (in_ch.coef_c),
    .out_valid (d_valid),
    .out_disc  (d_disc),
    .out_meta  (d_meta)
  );

  qrrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (d_valid),
    .in_disc   (d_disc),
    .in_meta   (d_meta),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_meta  (s_meta)
  );

  qrrs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s_valid),
    .in_root   (s_root),
    .in_meta   (s_meta),
    .out_valid (o_valid),
    .out_res   (o_res)
  );

  assign out_ch.valid      = o_valid;
  assign out_ch.root_plus  = o_res.root_plus;
  assign out_ch.root_minus = o_res.root_minus;
  assign out_ch.status     = o_res.status;

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && (o_res.status == ST_NO_ROOTS || o_res.status == ST_A_ZERO)
      |-> o_res.root_plus == '0 && o_res.root_minus == '0)
    else $error("flagged result carries nonzero roots");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_res.status == ST_SAT
      |-> o_res.root_plus == POS_LIM[OUT_WIDTH-1:0]
       || o_res.root_plus == SAT_MAG[OUT_WIDTH-1:0]
       || o_res.root_minus == POS_LIM[OUT_WIDTH-1:0]
       || o_res.root_minus == SAT_MAG[OUT_WIDTH-1:0])
    else $error("saturation flagged without a root at a limit");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !out_ch.ready |=> o_valid && $stable(o_res))
    else $error("stalled result lost or changed");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline is stalled");
endmodule

// File: verif/qrrs_checker.sv
`timescale 1ns / 1ps
module qrrs_checker (
  input  logic       clk,
  input  logic       rst_n,
  qrrs_in_if         in_ch,
  qrrs_out_if        out_ch,
  output int         fail_count,
  output int         root_count,
  output int         sat_count,
  output int         noroot_count,
  output int         azero_count
);
  import qrrs_pkg::*;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] root_plus;
    logic signed [OUT_WIDTH-1:0] root_minus;
    status_t                     status;
  } roots_t;

  roots_t pending_roots[$];

  function automatic logic [63:0] isqrt128(logic [127:0] x);
    logic [127:0] acc;
    logic [127:0] trial;
    logic [63:0]  r;
    acc = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = (({64'd0, r}) << (i + 1)) + (128'd1 << (2 * i));
      if (trial <= x - acc) begin
        acc = acc + trial;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  // divide signed numerator by 2a, truncate toward zero, saturate to OUT_WIDTH
  function automatic logic signed [OUT_WIDTH-1:0] scale_root(
    logic signed [127:0] num, logic signed [127:0] a, output logic sat);
    logic signed [127:0] q;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = (128'sd1 <<< (OUT_WIDTH - 1)) - 128'sd1;
    lo_lim = -(128'sd1 <<< (OUT_WIDTH - 1));
    q = (num <<< FRAC_BITS) / (a * 128'sd2);
    sat = 1'b0;
    if (q > hi_lim) begin
      sat = 1'b1;
      q = hi_lim;
    end else if (q < lo_lim) begin
      sat = 1'b1;
      q = lo_lim;
    end
    return q[OUT_WIDTH-1:0];
  endfunction

  function automatic roots_t solve_quadratic(logic signed [COEF_WIDTH-1:0] ca,
                                             logic signed [COEF_WIDTH-1:0] cb,
                                             logic signed [COEF_WIDTH-1:0] cc);
    roots_t r;
    logic signed [127:0] a, b, c, disc;
    logic [63:0] sq;
    logic s1, s2;
    a = 128'(ca);
    b = 128'(cb);
    c = 128'(cc);
    r.root_plus = '0;
    r.root_minus = '0;
    if (a == 0) begin
      r.status = ST_A_ZERO;
      return r;
    end
    disc = b * b - 128'sd4 * a * c;
    if (disc < 0) begin
      r.status = ST_NO_ROOTS;
      return r;
    end
    sq = isqrt128(disc);
    r.root_plus = scale_root(-b + $signed({64'd0, sq}), a, s1);
    r.root_minus = scale_root(-b - $signed({64'd0, sq}), a, s2);
    r.status = (s1 || s2) ? ST_SAT : ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    roots_t want;
    if (!rst_n) begin
      pending_roots.delete();
      fail_count <= 0;
      root_count <= 0;
      sat_count <= 0;
      noroot_count <= 0;
      azero_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        pending_roots.insert(pending_roots.size(),
                             solve_quadratic(in_ch.coef_a, in_ch.coef_b, in_ch.coef_c));
      if (out_ch.valid && out_ch.ready) begin
        root_count <= root_count + 1;
        case (out_ch.status)
          ST_SAT:      sat_count <= sat_count + 1;
          ST_NO_ROOTS: noroot_count <= noroot_count + 1;
          ST_A_ZERO:   azero_count <= azero_count + 1;
          default: ;
        endcase
        if (pending_roots.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result plus=%0d minus=%0d status=%0d", $realtime,
                     out_ch.root_plus, out_ch.root_minus, out_ch.status);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_roots.pop_front();
          if (want.root_plus !== out_ch.root_plus || want.root_minus !== out_ch.root_minus
              || want.status !== out_ch.status) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp plus=%0d minus=%0d status=%0d got %0d %0d %0d",
                       $realtime, want.root_plus, want.root_minus, want.status,
                       out_ch.root_plus, out_ch.root_minus, out_ch.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  function automatic int outstanding();
    return pending_roots.size();
  endfunction

endmodule

// File: verif/quadratic_real_root_solver_top_test.sv
`timescale 1ns / 1ps
module quadratic_real_root_solver_top_test;
  import qrrs_pkg::*;

  localparam int RANDOM_ITEMS = 1630;
  localparam int IDLE_LIMIT   = 20000;

  logic clk;
  logic rst_n;
  int   fail_count, root_count, sat_count, noroot_count, azero_count;
  int   idle_cycles;
  int   sent_count;
  bit   hold_off;

  qrrs_in_if  in_ch();
  qrrs_out_if out_ch();

  quadratic_real_root_solver_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  qrrs_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .root_count  (root_count),
    .sat_count   (sat_count),
    .noroot_count(noroot_count),
    .azero_count (azero_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // small-magnitude coefficients keep roots in range; full range hits saturation
  function automatic logic [COEF_WIDTH-1:0] pick_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000;
      2: return $signed($urandom_range(0, 32'h7ff_ffff)) - 32'sh400_0000;
      3: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
      4: return (32'h1 << $urandom_range(31)) ^ ($urandom_range(1) ? 32'hffff_ffff : 32'h0);
      default: return $signed($urandom_range(0, 2048)) - 32'sd1024 <<< 16;
    endcase
  endfunction

  task automatic send_eq(logic [COEF_WIDTH-1:0] a, logic [COEF_WIDTH-1:0] b,
                         logic [COEF_WIDTH-1:0] c);
    in_ch.valid  <= 1'b1;
    in_ch.coef_a <= a;
    in_ch.coef_b <= b;
    in_ch.coef_c <= c;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  task automatic send_with_gap(logic [COEF_WIDTH-1:0] a, logic [COEF_WIDTH-1:0] b,
                               logic [COEF_WIDTH-1:0] c);
    int g;
    send_eq(a, b, c);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // receiver: random stalls, plus one long hold-off while the sender keeps going
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [COEF_WIDTH-1:0] one;
    one = 32'h0001_0000;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;
    sent_count = 0;
    hold_off = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate, negative discriminant, double root, extremes
    send_eq(32'h0, 32'h0, 32'h0);
    send_eq(32'h0, 32'h7fff_ffff, 32'h8000_0000);
    send_eq(one, 32'h0, one);
    send_eq(one, 32'h0, -one);
    send_eq(one, -(2 * one), one);
    send_eq(one, -(3 * one), 2 * one);
    send_eq(-one, 32'h0, 4 * one);
    send_eq(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_eq(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_eq(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_eq(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_eq(32'h0000_0001, 32'h7fff_ffff, 32'h0);
    send_eq(32'h0000_0001, 32'h8000_0000, 32'h0);
    send_eq(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_eq(32'h0000_0001, 32'h0, 32'h8000_0000);
    send_eq(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_eq(2 * one, 32'h0000_0003, 32'h0);
    send_eq(-(2 * one), 32'h0000_0005, 32'h0000_0001);
    send_eq(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
    send_eq(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400) hold_off = 1'b1;
      if (i % 97 == 0) send_with_gap(32'h0, pick_coef(), pick_coef());
      else send_with_gap(pick_coef(), pick_coef(), pick_coef());
    end
    in_ch.valid <= 1'b0;

    // drain: poll once a cycle until every transaction has come back
    while (checker_i.outstanding() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Sent %0d equations, checked %0d results.", sent_count, root_count);
    $display("Saturated %0d, no real roots %0d, a zero %0d.", sat_count, noroot_count,
             azero_count);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hdl/qrrs_pkg.sv
hdl/qrrs_in_if.sv
hdl/qrrs_out_if.sv
hdl/qrrs_disc.sv
hdl/qrrs_sqrt.sv
hdl/qrrs_div.sv
hdl/quadratic_real_root_solver_top.sv
verif/qrrs_checker.sv
verif/quadratic_real_root_solver_top_test.sv
